// File: rtl/core/abl_pkg.sv
`default_nettype none

package abl_pkg;

    localparam int NUM_BUCKETS   = 256;
    localparam int NUM_WAYS      = 14;
    localparam int HISTORY_BYTES = 7;

    localparam int BKT_W      = $clog2(NUM_BUCKETS);
    localparam int SLOT_W     = 4;
    localparam int CHECK_W    = 16;
    localparam int HIST_W     = 8 * HISTORY_BYTES;
    localparam int OUT_HIST_W = 56;
    localparam int NIBBLE_W   = 4;
    localparam int RECENT_W   = 2 * NIBBLE_W;
    localparam int PRIO_W     = 9;

    // victim search tree
    localparam int TREE_LEVELS = $clog2(NUM_WAYS);
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    localparam logic [NIBBLE_W-1:0] NIBBLE_INVALID = 4'hf;
    localparam logic [PRIO_W-1:0]   PRIO_EXCLUDED  = 9'h100;
    localparam logic [PRIO_W-1:0]   PRIO_PAD       = 9'h1ff;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [1:0] OUT_RECENT_HIT = 2'd0;
    localparam logic [1:0] OUT_SCAN_HIT   = 2'd1;
    localparam logic [1:0] OUT_MISS       = 2'd2;
    localparam logic [1:0] OUT_WRITE      = 2'd3;

    typedef struct packed {
        logic                  opcode;
        logic [7:0]            bucket;
        logic [CHECK_W-1:0]    check_value;
        logic                  forget_older;
        logic [SLOT_W-1:0]     write_slot;
        logic [OUT_HIST_W-1:0] write_history;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [1:0]            outcome;
        logic [OUT_HIST_W-1:0] history;
    } result_t;

    // one bucket as stored in a single memory word
    typedef struct packed {
        logic [RECENT_W-1:0]                recent;
        logic [NUM_WAYS-1:0][CHECK_W-1:0]   checks;
        logic [NUM_WAYS-1:0][HIST_W-1:0]    hists;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

`default_nettype wire

// File: rtl/core/abl_ram.sv
`default_nettype none

module abl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/assoc_bucket_lookup_replace.sv
`default_nettype none

// channel   | ports              | handshake
// ----------+--------------------+----------------------------------------------
// request   | start, busy, req   | taken at a rising edge with start high, busy low
// result    | done, result       | valid for the one cycle done is high, no stall
//
// every request reads the bucket row from the row memory in the accept cycle
// and writes the modified row back in the next one, during which busy is high;
// the row memory read is registered
// the result is shown for one cycle right after the write-back cycle
// after reset every bucket reads as zero through a per-bucket valid bit, so no
// clearing pass is needed; the receiver cannot stall
module assoc_bucket_lookup_replace (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire abl_pkg::req_t   req,
    output logic                 done,
    output abl_pkg::result_t     result
);
    import abl_pkg::*;

    // control
    logic                   busy_reg;
    logic                   done_reg;
    logic                   row_valid_reg;
    logic [NUM_BUCKETS-1:0] bucket_valid_reg;
    logic                   accept;

    // payload
    req_t    req_reg;
    result_t result_reg;
    result_t result_next;

    // row memory
    logic [ROW_W-1:0] ram_rdata;
    row_t             row_cur;
    row_t             row_next;
    logic [BKT_W-1:0] rd_bucket;
    logic [BKT_W-1:0] wr_bucket;

    // lookup datapath
    logic [NIBBLE_W-1:0] r0;
    logic [NIBBLE_W-1:0] r1;
    logic [NUM_WAYS-1:0] hit;
    logic                recent_hit;
    logic                scan_hit;
    logic [SLOT_W-1:0]   scan_slot;
    logic [SLOT_W-1:0]   victim;
    logic [PRIO_W-1:0]   tree_key  [TREE_LEVELS+1][TREE_LEAVES];
    logic [SLOT_W-1:0]   tree_slot [TREE_LEVELS+1][TREE_LEAVES];

    assign accept    = start && !busy_reg;
    assign rd_bucket = req.bucket[BKT_W-1:0];
    assign wr_bucket = req_reg.bucket[BKT_W-1:0];

    abl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (wr_bucket),
        .wdata (row_next),
        .re    (accept),
        .raddr (rd_bucket),
        .rdata (ram_rdata)
    );

    // a bucket never written since reset reads as all zero
    assign row_cur = row_valid_reg ? row_t'(ram_rdata) : '0;
    assign r0      = row_cur.recent[NIBBLE_W-1:0];
    assign r1      = row_cur.recent[RECENT_W-1:NIBBLE_W];

    // compare all ways at once, then first-hit priority encode
    always_comb
    begin
        hit        = '0;
        recent_hit = 1'b0;
        scan_hit   = 1'b0;
        scan_slot  = '0;
        for (int s = 0; s < NUM_WAYS; s++)
        begin
            hit[s] = (row_cur.checks[s] == req_reg.check_value);
            if (hit[s] && (r0 == SLOT_W'(s)))
            begin
                recent_hit = 1'b1;
            end
        end
        for (int s = NUM_WAYS - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                scan_hit  = 1'b1;
                scan_slot = SLOT_W'(s);
            end
        end
    end

    // victim: lowest first history byte among ways outside the recent pair,
    // found by a min tree where the left (lower) way wins ties
    always_comb
    begin
        for (int lv = 0; lv <= TREE_LEVELS; lv++)
        begin
            for (int n = 0; n < TREE_LEAVES; n++)
            begin
                tree_key[lv][n]  = PRIO_PAD;
                tree_slot[lv][n] = '0;
            end
        end
        for (int s = 0; s < NUM_WAYS; s++)
        begin
            tree_slot[0][s] = SLOT_W'(s);
            if ((r0 == SLOT_W'(s)) || (r1 == SLOT_W'(s)))
            begin
                tree_key[0][s] = PRIO_EXCLUDED;
            end
            else
            begin
                tree_key[0][s] = {1'b0, row_cur.hists[s][7:0]};
            end
        end
        for (int lv = 0; lv < TREE_LEVELS; lv++)
        begin
            for (int n = 0; n < (TREE_LEAVES >> (lv + 1)); n++)
            begin
                if (tree_key[lv][2*n] <= tree_key[lv][2*n+1])
                begin
                    tree_key[lv+1][n]  = tree_key[lv][2*n];
                    tree_slot[lv+1][n] = tree_slot[lv][2*n];
                end
                else
                begin
                    tree_key[lv+1][n]  = tree_key[lv][2*n+1];
                    tree_slot[lv+1][n] = tree_slot[lv][2*n+1];
                end
            end
        end
        victim = tree_slot[TREE_LEVELS][0];
    end

    // row update and result for the request in flight
    always_comb
    begin
        row_next    = row_cur;
        result_next = '0;
        if (req_reg.opcode == OP_WRITE)
        begin
            result_next.slot    = req_reg.write_slot;
            result_next.outcome = OUT_WRITE;
            for (int s = 0; s < NUM_WAYS; s++)
            begin
                if (req_reg.write_slot == SLOT_W'(s))
                begin
                    row_next.hists[s]   = req_reg.write_history[HIST_W-1:0];
                    result_next.history = OUT_HIST_W'(req_reg.write_history[HIST_W-1:0]);
                end
            end
        end
        else if (recent_hit)
        begin
            // recent byte stays as it is
            result_next.slot    = r0;
            result_next.outcome = OUT_RECENT_HIT;
            for (int s = 0; s < NUM_WAYS; s++)
            begin
                if (r0 == SLOT_W'(s))
                begin
                    result_next.history = OUT_HIST_W'(row_cur.hists[s]);
                end
            end
        end
        else if (scan_hit)
        begin
            row_next.recent     = {r0, scan_slot};
            result_next.slot    = scan_slot;
            result_next.outcome = OUT_SCAN_HIT;
            for (int s = 0; s < NUM_WAYS; s++)
            begin
                if (scan_slot == SLOT_W'(s))
                begin
                    result_next.history = OUT_HIST_W'(row_cur.hists[s]);
                end
            end
        end
        else
        begin
            // miss: take over the victim way with a clean history
            row_next.recent = {(req_reg.forget_older ? NIBBLE_INVALID : r0), victim};
            for (int s = 0; s < NUM_WAYS; s++)
            begin
                if (victim == SLOT_W'(s))
                begin
                    row_next.checks[s] = req_reg.check_value;
                    row_next.hists[s]  = '0;
                end
            end
            result_next.slot    = victim;
            result_next.outcome = OUT_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            row_valid_reg    <= 1'b0;
            bucket_valid_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (accept)
            begin
                busy_reg      <= 1'b1;
                row_valid_reg <= bucket_valid_reg[rd_bucket];
            end
            else if (busy_reg)
            begin
                busy_reg                    <= 1'b0;
                bucket_valid_reg[wr_bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // busy drops again right after the write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("busy held longer than one cycle");

    // an accepted request always enters the write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not start");

    // each result follows its write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> done)
        else $error("result missing after write-back");

    // a replaced slot reports an empty history
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.outcome == OUT_MISS)) |-> (result.history == '0))
        else $error("miss reported nonzero history");

    // lookups only ever name a real way
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.outcome != OUT_WRITE)) |-> (result.slot < SLOT_W'(NUM_WAYS)))
        else $error("lookup slot out of range");

endmodule

`default_nettype wire

// File: tb/sv/tb_assoc_bucket_lookup_replace.sv
module tb_assoc_bucket_lookup_replace;
    timeunit 1ns;
    timeprecision 1ps;

    import abl_pkg::*;

    // generous bound for all 1568 requests, even with the longest sender gaps
    localparam int CYCLE_LIMIT = 200_000;
    localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
    // history bits that a slot actually keeps
    localparam logic [OUT_HIST_W-1:0] HIST_KEEP = {OUT_HIST_W{1'b1}} >> (OUT_HIST_W - HIST_W);
    localparam logic [OUT_HIST_W-1:0] HIST_ONES = {OUT_HIST_W{1'b1}};

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    req_t    req;
    logic    done;
    result_t result;

    assoc_bucket_lookup_replace i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always #5ns clk = ~clk;

    // shadow copy of the bucket store, kept in step with accepted requests
    logic [CHECK_W-1:0]    shadow_checks [NUM_SLOTS];
    logic [OUT_HIST_W-1:0] shadow_hists  [NUM_SLOTS];
    logic [RECENT_W-1:0]   shadow_recent [NUM_BUCKETS];

    // results still owed by the block, oldest first
    result_t expected_results [$];

    int n_errors  = 0;
    int n_sent    = 0;
    int n_cycles  = 0;
    int outcome_seen [4] = '{default: 0};

    // sender burst state
    int burst_left = 0;

    // buckets that get most of the traffic during a phase
    logic [7:0] hot_buckets [4];

    // ------------------------------------------------------------------
    // predictor: applies one request to the shadow store and returns the
    // result the block must give for it
    // ------------------------------------------------------------------
    function automatic result_t predict_bucket_op(req_t r);
        result_t             res;
        int                  base;
        int                  bkt;
        int                  recent_slot;
        int                  older_slot;
        int                  victim;
        int                  best_prio;
        int                  first_byte;
        logic [RECENT_W-1:0] last;
        res         = '0;
        bkt         = int'(r.bucket) % NUM_BUCKETS;
        base        = bkt * NUM_WAYS;
        last        = shadow_recent[bkt];
        recent_slot = int'(last[NIBBLE_W-1:0]);
        older_slot  = int'(last[RECENT_W-1:NIBBLE_W]);

        // history write: out-of-range slot leaves the store alone, history zero
        if (r.opcode == OP_WRITE) begin
            res.slot    = r.write_slot;
            res.outcome = OUT_WRITE;
            if (int'(r.write_slot) < NUM_WAYS) begin
                shadow_hists[base + int'(r.write_slot)] = r.write_history & HIST_KEEP;
                res.history = shadow_hists[base + int'(r.write_slot)];
            end
            return res;
        end

        // most recent slot first; recent byte stays as it is
        if (recent_slot < NUM_WAYS && shadow_checks[base + recent_slot] == r.check_value) begin
            res.slot    = SLOT_W'(recent_slot);
            res.outcome = OUT_RECENT_HIT;
            res.history = shadow_hists[base + recent_slot];
            return res;
        end

        // in-order scan, first match wins and becomes most recent
        for (int s = 0; s < NUM_WAYS; s++) begin
            if (shadow_checks[base + s] == r.check_value) begin
                shadow_recent[bkt] = {last[NIBBLE_W-1:0], NIBBLE_W'(s)};
                res.slot    = SLOT_W'(s);
                res.outcome = OUT_SCAN_HIT;
                res.history = shadow_hists[base + s];
                return res;
            end
        end

        // miss: lowest history byte 0 outside the recent pair, lowest index on ties
        best_prio = 'hffff;
        victim    = 0;
        for (int s = 0; s < NUM_WAYS; s++) begin
            first_byte = int'(shadow_hists[base + s][7:0]);
            if (s != recent_slot && s != older_slot && first_byte < best_prio) begin
                best_prio = first_byte;
                victim    = s;
            end
        end
        shadow_recent[bkt] = {(r.forget_older ? NIBBLE_INVALID : last[NIBBLE_W-1:0]),
                              NIBBLE_W'(victim)};
        shadow_checks[base + victim] = r.check_value;
        shadow_hists[base + victim]  = '0;
        res.slot    = SLOT_W'(victim);
        res.outcome = OUT_MISS;
        return res;
    endfunction

    function automatic req_t make_req(logic op, logic [7:0] bkt, logic [CHECK_W-1:0] cv,
                                      logic forget, logic [SLOT_W-1:0] wslot,
                                      logic [OUT_HIST_W-1:0] whist);
        req_t r;
        r.opcode        = op;
        r.bucket        = bkt;
        r.check_value   = cv;
        r.forget_older  = forget;
        r.write_slot    = wslot;
        r.write_history = whist;
        return r;
    endfunction

    // random request; hot_only keeps buckets and check values in small pools
    // so buckets fill up, hit and get thrashed
    function automatic req_t random_req(bit hot_only);
        req_t                  r;
        logic [63:0]           wide;
        wide            = {$urandom, $urandom};
        r.opcode        = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_LOOKUP;
        r.bucket        = (hot_only && $urandom_range(0, 9) != 0)
                          ? hot_buckets[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
        // about 22 live check values per bucket against 14 ways
        if (hot_only && $urandom_range(0, 9) != 0)
            r.check_value = {r.bucket, 8'($urandom_range(0, 21))};
        else if ($urandom_range(0, 7) == 0)
            r.check_value = '0;
        else
            r.check_value = CHECK_W'($urandom);
        r.forget_older  = 1'($urandom_range(0, 1));
        r.write_slot    = ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(NUM_WAYS, 15))
                                                      : SLOT_W'($urandom_range(0, NUM_WAYS - 1));
        r.write_history = wide[OUT_HIST_W-1:0];
        // crowd byte 0 into a few values so victim ties are common
        if ($urandom_range(0, 2) != 0)
            r.write_history[7:0] = 8'($urandom_range(0, 3));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: called at a falling edge, returns at the falling edge after
    // the request was taken with start still high; bursts of random length
    // separated by random gaps
    // ------------------------------------------------------------------
    task automatic send_req(req_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // only drop start when there really is a gap
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start = 1'b1;
        req   = r;
        // taken at the first rising edge with busy low
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.push_back(predict_bucket_op(r));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        start = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        // the result comes right after its write-back cycle; then idle on as a margin
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked sequence on buckets 0, 128 and 255 starting from the
    // cleared store
    task automatic test_reset_and_corner_cases();
        // cleared store: slot 0 already holds check 0, recent hit
        send_req(make_req(OP_LOOKUP, 8'd0, 16'h0000, 1'b0, 4'd0, '0));
        // miss, slot 0 is both recent entries so slot 1 is the victim
        send_req(make_req(OP_LOOKUP, 8'd0, 16'hffff, 1'b0, 4'd0, '0));
        send_req(make_req(OP_LOOKUP, 8'd0, 16'hffff, 1'b0, 4'd0, '0));
        // recent slot misses, found by the scan at slot 0
        send_req(make_req(OP_LOOKUP, 8'd0, 16'h0000, 1'b0, 4'd0, '0));
        // history writes: top slot, both out-of-range slot codes, byte 0 set
        send_req(make_req(OP_WRITE, 8'd0, 16'h0000, 1'b0, 4'd13, HIST_ONES));
        send_req(make_req(OP_WRITE, 8'd0, 16'h0000, 1'b0, 4'd14, 56'h00_0000_0000_0042));
        send_req(make_req(OP_WRITE, 8'd0, 16'hffff, 1'b1, 4'd15, HIST_ONES));
        send_req(make_req(OP_WRITE, 8'd0, 16'h0000, 1'b0, 4'd0, 56'h00_0000_0000_0080));
        send_req(make_req(OP_WRITE, 8'd0, 16'h0000, 1'b0, 4'd2, 56'h00_0000_0000_0005));
        // miss with forget: slots 0 and 1 excluded, slot 2 has byte 0 of 5 so slot 3 wins
        send_req(make_req(OP_LOOKUP, 8'd0, 16'h1111, 1'b1, 4'd0, '0));
        // older entry now invalid and excludes nothing
        send_req(make_req(OP_LOOKUP, 8'd0, 16'h2222, 1'b0, 4'd0, '0));
        send_req(make_req(OP_LOOKUP, 8'd0, 16'h1111, 1'b0, 4'd0, '0));
        // top bucket
        send_req(make_req(OP_LOOKUP, 8'd255, 16'habcd, 1'b1, 4'd0, '0));
        send_req(make_req(OP_WRITE, 8'd255, 16'h0000, 1'b0, 4'd13, 56'h01_2345_6789_abcd));
        send_req(make_req(OP_LOOKUP, 8'd255, 16'h0000, 1'b0, 4'd0, '0));
        send_req(make_req(OP_LOOKUP, 8'd255, 16'habcd, 1'b0, 4'd0, '0));
        // lookup with write fields set, write with lookup fields set
        send_req(make_req(OP_LOOKUP, 8'd128, 16'h0000, 1'b1, 4'd15, HIST_ONES));
        send_req(make_req(OP_WRITE, 8'd128, 16'hffff, 1'b1, 4'd7, '0));
    endtask

    // most traffic on a few buckets so they fill, hit and thrash
    task automatic test_hot_bucket_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            foreach (hot_buckets[i])
                hot_buckets[i] = 8'($urandom_range(0, 255));
            // edge buckets get their share in the first phase
            if (phase == 0) begin
                hot_buckets[0] = 8'd0;
                hot_buckets[1] = 8'd255;
            end
            repeat (470) send_req(random_req(1'b1));
        end
    endtask

    // values spread over the whole field ranges, mostly misses
    task automatic test_scattered_traffic();
        repeat (140) send_req(random_req(1'b0));
    endtask

    // ------------------------------------------------------------------
    // result checker: compares each result with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] expv, logic [63:0] actv);
        if (actv !== expv) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with none expected, expected none actual %h",
                         $time, result);
            end else begin
                want = expected_results.pop_front();
                check_field("slot", 64'(want.slot), 64'(result.slot));
                check_field("outcome", 64'(want.outcome), 64'(result.outcome));
                check_field("history", 64'(want.history), 64'(result.history));
                outcome_seen[want.outcome]++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, n_cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        // shadow store matches the cleared block
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_checks[i] = '0;
            shadow_hists[i]  = '0;
        end
        for (int i = 0; i < NUM_BUCKETS; i++)
            shadow_recent[i] = '0;
        foreach (hot_buckets[i])
            hot_buckets[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_and_corner_cases();
        test_hot_bucket_traffic();
        test_scattered_traffic();
        wait_for_results();

        $display("covered %0d requests in %0d cycles", n_sent, n_cycles);
        $display("outcomes: %0d recent hits, %0d scan hits, %0d misses, %0d writes",
                 outcome_seen[OUT_RECENT_HIT], outcome_seen[OUT_SCAN_HIT],
                 outcome_seen[OUT_MISS], outcome_seen[OUT_WRITE]);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
